// ===== hw/rtl/double_ended_queue_assert.svh =====
// assertion macros for the double-ended queue
// expects clock and reset in the scope of the asserting module
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// single property, sampled on clock, off during reset
`define DEQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// antecedent in this cycle implies consequent in the next
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
// shared types and codes for the double-ended queue
// no dependencies
`default_nettype none

package deq_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic [2:0] {
      DEQ_OP_PUSH_FRONT    = 3'd0,
      DEQ_OP_PUSH_BACK     = 3'd1,
      DEQ_OP_DISCARD_FRONT = 3'd2,
      DEQ_OP_DISCARD_BACK  = 3'd3,
      DEQ_OP_CLEAR         = 3'd4,
      DEQ_OP_QUERY         = 3'd5
   } deq_op_type;

   typedef enum logic [1:0] {
      DEQ_ST_DONE  = 2'd0,
      DEQ_ST_FULL  = 2'd1,
      DEQ_ST_EMPTY = 2'd2
   } deq_status_type;

   typedef enum logic {
      DEQ_IDLE = 1'b0,
      DEQ_READ = 1'b1
   } deq_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue on a ring of DEPTH entries in one synchronous RAM
// (registered read data). Every request transfer yields exactly one response
// transfer with a status, the front and back entries with valid flags, the
// entry count and an empty flag, all as they stand after the operation. Op
// codes: push front, push back, discard front, discard back, clear, query;
// the two unused codes behave as a query. A push into a full ring is refused
// with the full status and a discard on an empty ring is ignored with the
// empty status, both leaving the state alone. The front and back entries are
// held in cache registers next to the RAM, so pushes, clears, queries and
// discards that leave the queue empty need no RAM read. A discard that
// leaves entries behind passes through the READ state: the new front or
// back entry has to be fetched from the RAM, whose read data is registered.
// The response sits in an output register; a new request transfer is taken
// in the same cycle the pending response is transferred, so the block
// sustains one item per cycle while rsp_stall is low, except for those
// discards, which stall requests. Front and back read as zero when empty. Entries
// are kept in DATA_WIDTH bits: pushed values are truncated to DATA_WIDTH
// bits, and the 32-bit response fields carry the low 32 bits of an entry.
// Depends on deq_pkg and double_ended_queue_assert.svh.
`default_nettype none

`include "double_ended_queue_assert.svh"

module double_ended_queue #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32,
   localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [2:0]                   req_op,
   input  wire  [deq_pkg::VALUE_W-1:0]  req_item_value,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [deq_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic                         rsp_front_valid,
   output logic [deq_pkg::VALUE_W-1:0]  rsp_back_value,
   output logic                         rsp_back_valid,
   output logic [CNT_W-1:0]             rsp_entry_count,
   output logic                         rsp_is_empty
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   // common width for moving between entry width and the 32-bit ports
   localparam int unsigned EXT_W = (DATA_WIDTH > deq_pkg::VALUE_W) ?
                                   DATA_WIDTH : deq_pkg::VALUE_W;

   // ring index helpers, DEPTH need not be a power of two
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

   // control state
   deq_pkg::deq_state_type state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // cached end entries and the pending discard side
   logic [DATA_WIDTH-1:0]  front_ff, front_in;
   logic [DATA_WIDTH-1:0]  back_ff, back_in;
   logic                   pend_front_ff, pend_front_in;

   // entry ram
   logic [DATA_WIDTH-1:0]  mem [DEPTH];
   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0]  rd_data_ff;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   deq_pkg::deq_status_type         rsp_status_ff, status_in;
   logic [deq_pkg::VALUE_W-1:0]     rsp_front_ff, rsp_front_in;
   logic [deq_pkg::VALUE_W-1:0]     rsp_back_ff, rsp_back_in;
   logic [CNT_W-1:0]                rsp_count_ff;
   logic                            rsp_any_ff;

   // handshake and sequencing
   logic                   req_accept;
   logic                   in_idle;
   logic                   in_read;
   logic                   need_read;
   logic                   rsp_load;

   // push data and response value conversion
   logic [EXT_W-1:0]       push_ext;
   logic [DATA_WIDTH-1:0]  push_data;
   logic [EXT_W-1:0]       front_ext;
   logic [EXT_W-1:0]       back_ext;
   logic                   count_full;
   logic                   count_zero;
   logic                   count_one;

   // terms for the checks at the end
   logic                   discard_fetch;
   logic                   push_taken;
   logic [CNT_W-1:0]       count_up;

   assign push_ext   = EXT_W'(req_item_value);
   assign push_data  = push_ext[DATA_WIDTH-1:0];
   assign count_full = (count_ff == CNT_W'(DEPTH));
   assign count_zero = (count_ff == '0);
   assign count_one  = (count_ff == CNT_W'(1));

   assign req_accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         deq_pkg::DEQ_IDLE: begin
            if (req_accept && need_read) begin
               state_in = deq_pkg::DEQ_READ;
            end
         end
         deq_pkg::DEQ_READ: begin
            state_in = deq_pkg::DEQ_IDLE;
         end
         default: begin
            state_in = deq_pkg::DEQ_IDLE;
         end
      endcase
   end

   // state outputs: take a request only when idle and the response slot
   // is free or being transferred this cycle
   always_comb begin
      in_idle = 1'b0;
      in_read = 1'b0;
      case (state_ff)
         deq_pkg::DEQ_IDLE: in_idle = 1'b1;
         deq_pkg::DEQ_READ: in_read = 1'b1;
         default:           in_idle = 1'b0;
      endcase
      req_stall = !(in_idle && (!rsp_valid_ff || !rsp_stall));
      rsp_load  = (in_idle && req_accept && !need_read) || in_read;
   end

   // operation datapath: ring pointers, ram access and cache update
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      pend_front_in = pend_front_ff;
      status_in     = deq_pkg::DEQ_ST_DONE;
      mem_we        = 1'b0;
      wr_addr       = tail_ff;
      rd_addr       = head_ff;
      need_read     = 1'b0;

      if (in_read) begin
         // fetched entry becomes the new end of the queue
         if (pend_front_ff) begin
            front_in = rd_data_ff;
         end else begin
            back_in = rd_data_ff;
         end
      end else if (req_accept) begin
         case (deq_pkg::deq_op_type'(req_op))
            deq_pkg::DEQ_OP_PUSH_FRONT: begin
               if (count_full) begin
                  status_in = deq_pkg::DEQ_ST_FULL;
               end else begin
                  head_in  = ring_prev(head_ff);
                  wr_addr  = head_in;
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  front_in = push_data;
                  if (count_zero) begin
                     back_in = push_data;
                  end
               end
            end
            deq_pkg::DEQ_OP_PUSH_BACK: begin
               if (count_full) begin
                  status_in = deq_pkg::DEQ_ST_FULL;
               end else begin
                  wr_addr  = tail_ff;
                  mem_we   = 1'b1;
                  tail_in  = ring_next(tail_ff);
                  count_in = count_ff + CNT_W'(1);
                  back_in  = push_data;
                  if (count_zero) begin
                     front_in = push_data;
                  end
               end
            end
            deq_pkg::DEQ_OP_DISCARD_FRONT: begin
               if (count_zero) begin
                  status_in = deq_pkg::DEQ_ST_EMPTY;
               end else begin
                  head_in  = ring_next(head_ff);
                  count_in = count_ff - CNT_W'(1);
                  if (!count_one) begin
                     rd_addr       = head_in;
                     need_read     = 1'b1;
                     pend_front_in = 1'b1;
                  end
               end
            end
            deq_pkg::DEQ_OP_DISCARD_BACK: begin
               if (count_zero) begin
                  status_in = deq_pkg::DEQ_ST_EMPTY;
               end else begin
                  tail_in  = ring_prev(tail_ff);
                  count_in = count_ff - CNT_W'(1);
                  if (!count_one) begin
                     rd_addr       = ring_prev(tail_in);
                     need_read     = 1'b1;
                     pend_front_in = 1'b0;
                  end
               end
            end
            deq_pkg::DEQ_OP_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
               // query and the unused codes leave the state alone
               count_in = count_ff;
            end
         endcase
      end
   end

   assign mem_re = need_read;

   // response payload from the post-operation state, zero values when empty
   assign front_ext    = EXT_W'(front_in);
   assign back_ext     = EXT_W'(back_in);
   assign rsp_front_in = (count_in != '0) ? front_ext[deq_pkg::VALUE_W-1:0] : '0;
   assign rsp_back_in  = (count_in != '0) ? back_ext[deq_pkg::VALUE_W-1:0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // entry ram, write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= push_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::DEQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      pend_front_ff <= pend_front_in;
      if (rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_front_ff  <= rsp_front_in;
         rsp_back_ff   <= rsp_back_in;
         rsp_count_ff  <= count_in;
         rsp_any_ff    <= (count_in != '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_front_valid = rsp_any_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_back_valid  = rsp_any_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = !rsp_any_ff;

   assign discard_fetch = req_accept && (count_ff > CNT_W'(1)) &&
                          ((req_op == deq_pkg::DEQ_OP_DISCARD_FRONT) ||
                           (req_op == deq_pkg::DEQ_OP_DISCARD_BACK));
   assign push_taken    = req_accept && !count_full &&
                          ((req_op == deq_pkg::DEQ_OP_PUSH_FRONT) ||
                           (req_op == deq_pkg::DEQ_OP_PUSH_BACK));
   assign count_up      = count_ff + CNT_W'(1);

   // count stays within the ring
   `DEQ_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   // a ram fetch only runs with the response slot empty
   `DEQ_ASSERT(a_read_slot_free, in_read |-> !rsp_valid_ff, "fetch with response pending")
   // a discard that leaves entries fetches the new end entry
   `DEQ_ASSERT_NEXT(a_discard_fetch, discard_fetch, in_read, "discard without fetch")
   // an accepted push into a non-full ring adds one entry
   `DEQ_ASSERT_NEXT(a_push_count, push_taken, count_ff == $past(count_up), "push not counted")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for double_ended_queue: directed table then random operations with
// randomized sender bursts and receiver stalls, every response checked in order
// depends on deq_pkg and the double_ended_queue rtl
`default_nettype none

module tb_top;

   localparam int unsigned DEPTH        = 16;
   localparam int unsigned IDX_W        = $clog2(DEPTH);
   localparam int unsigned COUNT_W      = $clog2(DEPTH + 1);
   localparam int unsigned RANDOM_ITEMS = 1100;
   localparam int unsigned LIMIT_CYCLES = 400000;

   // the two op codes the package leaves unnamed, both act as a query
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // receiver stall behavior, picked anew whenever its stretch runs out
   typedef enum logic [1:0] {
      STALL_NONE     = 2'd0,
      STALL_LIGHT    = 2'd1,
      STALL_HEAVY    = 2'd2,
      STALL_PERIODIC = 2'd3
   } stall_mode_type;

   // one response as the block reports it
   typedef struct packed {
      deq_pkg::deq_status_type status;
      logic [31:0]             front_value;
      logic                    front_valid;
      logic [31:0]             back_value;
      logic                    back_valid;
      logic [COUNT_W-1:0]      entry_count;
      logic                    is_empty;
   } deq_result_type;

   // one row of the directed table; typed rows carry a hand-written response
   typedef struct {
      logic [2:0]       op;
      logic [31:0]      value;
      bit               typed;
      deq_result_type   expected;
   } stim_row_type;

   // clock, reset and block ports; the bench-driven ones are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_op = deq_pkg::DEQ_OP_QUERY;
   logic [31:0]           req_item_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [31:0]           rsp_front_value;
   logic                  rsp_front_valid;
   logic [31:0]           rsp_back_value;
   logic                  rsp_back_valid;
   logic [COUNT_W-1:0]    rsp_entry_count;
   logic                  rsp_is_empty;

   // side data that travels with the request payload
   bit                    row_typed = 1'b0;
   deq_result_type        row_expected = '0;

   // shadow deque kept by the checker
   logic [31:0]           shadow_store [DEPTH];
   logic [IDX_W-1:0]      shadow_head = '0;
   logic [IDX_W-1:0]      shadow_tail = '0;
   logic [COUNT_W-1:0]    shadow_count = '0;

   deq_result_type        pending_results [$];
   stim_row_type          directed_rows [$];
   int unsigned           error_count = 0;

   stall_mode_type        stall_mode = STALL_NONE;
   int unsigned           stall_left = 0;
   logic [7:0]            stall_phase = '0;

   double_ended_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (32)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_front_value (rsp_front_value),
      .rsp_front_valid (rsp_front_valid),
      .rsp_back_value  (rsp_back_value),
      .rsp_back_valid  (rsp_back_valid),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ring index helpers for the shadow deque
   function automatic logic [IDX_W-1:0] ring_after(input logic [IDX_W-1:0] idx);
      return (idx == DEPTH - 1) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_before(input logic [IDX_W-1:0] idx);
      return (idx == 0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
   endfunction

   // apply one operation to the shadow deque and return the response it gives
   function automatic deq_result_type predict_deque_result(input logic [2:0] op,
                                                           input logic [31:0] value);
      deq_result_type res;
      deq_pkg::deq_status_type st;
      st = deq_pkg::DEQ_ST_DONE;
      case (op)
         deq_pkg::DEQ_OP_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               st = deq_pkg::DEQ_ST_FULL;
            end else begin
               shadow_head = ring_before(shadow_head);
               shadow_store[shadow_head] = value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         deq_pkg::DEQ_OP_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               st = deq_pkg::DEQ_ST_FULL;
            end else begin
               shadow_store[shadow_tail] = value;
               shadow_tail = ring_after(shadow_tail);
               shadow_count = shadow_count + 1'b1;
            end
         end
         deq_pkg::DEQ_OP_DISCARD_FRONT: begin
            if (shadow_count == 0) begin
               st = deq_pkg::DEQ_ST_EMPTY;
            end else begin
               shadow_head = ring_after(shadow_head);
               shadow_count = shadow_count - 1'b1;
            end
         end
         deq_pkg::DEQ_OP_DISCARD_BACK: begin
            if (shadow_count == 0) begin
               st = deq_pkg::DEQ_ST_EMPTY;
            end else begin
               shadow_tail = ring_before(shadow_tail);
               shadow_count = shadow_count - 1'b1;
            end
         end
         deq_pkg::DEQ_OP_CLEAR: begin
            shadow_head = '0;
            shadow_tail = '0;
            shadow_count = '0;
         end
         default: begin
         end
      endcase
      res = '0;
      res.status = st;
      res.entry_count = shadow_count;
      res.is_empty = (shadow_count == 0);
      // front and back only carry data when something is held
      if (shadow_count != 0) begin
         res.front_value = shadow_store[shadow_head];
         res.front_valid = 1'b1;
         res.back_value = shadow_store[ring_before(shadow_tail)];
         res.back_valid = 1'b1;
      end
      return res;
   endfunction

   function automatic deq_result_type make_result(input deq_pkg::deq_status_type st,
                                                  input logic [31:0] fv, input logic fvld,
                                                  input logic [31:0] bv, input logic bvld,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic empty_flag);
      deq_result_type res;
      res.status = st;
      res.front_value = fv;
      res.front_valid = fvld;
      res.back_value = bv;
      res.back_valid = bvld;
      res.entry_count = cnt;
      res.is_empty = empty_flag;
      return res;
   endfunction

   function automatic void add_row(input logic [2:0] op, input logic [31:0] value,
                                   input bit typed, input deq_result_type expected);
      stim_row_type row;
      row.op = op;
      row.value = value;
      row.typed = typed;
      row.expected = expected;
      directed_rows.push_back(row);
   endfunction

   // one field compare
   function automatic void compare_field(input string name, input logic [31:0] expected,
                                         input logic [31:0] actual);
      if (actual !== expected) begin
         error_count++;
         $display("%0t: mismatch on %s, expected %h, actual %h",
                  $time, name, expected, actual);
      end
   endfunction

   // offer one item and hold it until the transfer happens
   task automatic send_item(input logic [2:0] op, input logic [31:0] value,
                            input bit typed, input deq_result_type expected);
      req_valid <= 1'b1;
      req_op <= op;
      req_item_value <= value;
      row_typed <= typed;
      row_expected <= expected;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender gap with junk on the payload
   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      req_op <= 3'($urandom);
      req_item_value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off until every outstanding response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern: off, light, heavy or periodic, in random stretches
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         default:        rsp_stall <= stall_phase[2] & stall_phase[0];
      endcase
   end

   // request transfers feed the shadow deque, response transfers are checked in order
   always @(posedge clock) begin : result_check
      deq_result_type predicted;
      deq_result_type wanted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = predict_deque_result(req_op, req_item_value);
            pending_results.push_back(row_typed ? row_expected : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_status);
            end else begin
               wanted = pending_results.pop_front();
               compare_field("status", 32'(wanted.status), 32'(rsp_status));
               compare_field("front_value", wanted.front_value, rsp_front_value);
               compare_field("front_valid", 32'(wanted.front_valid), 32'(rsp_front_valid));
               compare_field("back_value", wanted.back_value, rsp_back_value);
               compare_field("back_valid", 32'(wanted.back_valid), 32'(rsp_back_valid));
               compare_field("entry_count", 32'(wanted.entry_count), 32'(rsp_entry_count));
               compare_field("is_empty", 32'(wanted.is_empty), 32'(rsp_is_empty));
            end
         end
      end
   end

   initial begin : stimulus
      deq_result_type blank;
      deq_result_type idle_result;
      logic [2:0]     op;
      logic [31:0]    value;
      int unsigned    sent;
      int unsigned    burst_left;
      int unsigned    phase_left;
      int unsigned    push_pct;
      int unsigned    pick;
      int unsigned    drain_wait;

      blank = '0;
      idle_result = make_result(deq_pkg::DEQ_ST_DONE, '0, 1'b0, '0, 1'b0, '0, 1'b1);

      // directed table: empty discards, extremes, unused codes, full ring, clear
      add_row(deq_pkg::DEQ_OP_QUERY, 32'h0, 1'b1, idle_result);
      add_row(deq_pkg::DEQ_OP_DISCARD_FRONT, $urandom, 1'b1,
              make_result(deq_pkg::DEQ_ST_EMPTY, '0, 1'b0, '0, 1'b0, '0, 1'b1));
      add_row(deq_pkg::DEQ_OP_DISCARD_BACK, $urandom, 1'b1,
              make_result(deq_pkg::DEQ_ST_EMPTY, '0, 1'b0, '0, 1'b0, '0, 1'b1));
      add_row(deq_pkg::DEQ_OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b1,
              make_result(deq_pkg::DEQ_ST_DONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                          COUNT_W'(1), 1'b0));
      add_row(deq_pkg::DEQ_OP_PUSH_FRONT, 32'h0, 1'b1,
              make_result(deq_pkg::DEQ_ST_DONE, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b1,
                          COUNT_W'(2), 1'b0));
      add_row(OP_UNUSED_LO, $urandom, 1'b0, blank);
      add_row(OP_UNUSED_HI, $urandom, 1'b0, blank);
      // fill up to the last slot, the final push lands 32'h8000_0000 at the back
      for (int i = 0; i < DEPTH - 2; i++) begin
         add_row(deq_pkg::DEQ_OP_PUSH_BACK, 32'h1 << (i + 18), 1'b0, blank);
      end
      add_row(deq_pkg::DEQ_OP_PUSH_FRONT, 32'h5555_5555, 1'b1,
              make_result(deq_pkg::DEQ_ST_FULL, 32'h0, 1'b1, 32'h8000_0000, 1'b1,
                          COUNT_W'(DEPTH), 1'b0));
      // discards that leave entries behind go through the ram fetch
      add_row(deq_pkg::DEQ_OP_DISCARD_FRONT, 32'h0, 1'b0, blank);
      add_row(deq_pkg::DEQ_OP_DISCARD_BACK, 32'h0, 1'b0, blank);
      add_row(deq_pkg::DEQ_OP_CLEAR, 32'h0, 1'b1, idle_result);
      add_row(deq_pkg::DEQ_OP_PUSH_FRONT, 32'h0F0F_F0F0, 1'b1,
              make_result(deq_pkg::DEQ_ST_DONE, 32'h0F0F_F0F0, 1'b1, 32'h0F0F_F0F0, 1'b1,
                          COUNT_W'(1), 1'b0));
      add_row(deq_pkg::DEQ_OP_DISCARD_BACK, 32'h0, 1'b1, idle_result);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].expected);
         if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
      end
      wait_for_drain();

      // random part: phases lean toward filling, mixing or draining the ring
      burst_left = 0;
      phase_left = 0;
      push_pct = 50;
      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 75;
               1:       push_pct = 50;
               default: push_pct = 25;
            endcase
            phase_left = $urandom_range(30, 120);
         end
         // one full drain in the middle of the run
         if (sent == RANDOM_ITEMS / 2) wait_for_drain();

         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            op = ($urandom_range(0, 1) != 0) ? deq_pkg::DEQ_OP_PUSH_FRONT :
                                               deq_pkg::DEQ_OP_PUSH_BACK;
         end else if (pick < 94) begin
            op = ($urandom_range(0, 1) != 0) ? deq_pkg::DEQ_OP_DISCARD_FRONT :
                                               deq_pkg::DEQ_OP_DISCARD_BACK;
         end else if (pick < 96) begin
            op = deq_pkg::DEQ_OP_QUERY;
         end else if (pick < 97) begin
            op = OP_UNUSED_LO;
         end else if (pick < 98) begin
            op = OP_UNUSED_HI;
         end else begin
            op = deq_pkg::DEQ_OP_CLEAR;
         end

         case ($urandom_range(0, 9))
            0:       value = 32'h0;
            1:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
         endcase

         send_item(op, value, 1'b0, blank);
         phase_left--;

         // bursts of random length, a third of them run straight into the next
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
         end else begin
            burst_left--;
         end
      end

      // let the last responses come back, then idle before the verdict
      req_valid <= 1'b0;
      drain_wait = 0;
      @(posedge clock);
      while (pending_results.size() != 0 && drain_wait < 2000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (16) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0) begin
         $display("double_ended_queue test passed");
      end else begin
         $display("double_ended_queue test failed");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("double_ended_queue test failed");
      $finish;
   end

endmodule

`default_nettype wire
